/* rtl/rrts_pkg.sv */
// ============================================================================
// rrts_pkg: shared types and constants for the round-robin thread scheduler
// Thread state codes, request and status codes, controller command struct.
// ============================================================================
package rrts_pkg;

    localparam int MAX_THREADS_DEF = 16;

    localparam logic [2:0] TS_UNUSED    = 3'd0;
    localparam logic [2:0] TS_READY     = 3'd1;
    localparam logic [2:0] TS_RUNNING   = 3'd2;
    localparam logic [2:0] TS_BLOCKED   = 3'd3;
    localparam logic [2:0] TS_SUSPENDED = 3'd4;
    localparam logic [2:0] TS_FINISHED  = 3'd5;

    localparam logic [2:0] REQ_CREATE    = 3'd0;
    localparam logic [2:0] REQ_YIELD     = 3'd1;
    localparam logic [2:0] REQ_JOIN      = 3'd2;
    localparam logic [2:0] REQ_SUSPEND   = 3'd3;
    localparam logic [2:0] REQ_RESUME    = 3'd4;
    localparam logic [2:0] REQ_TERMINATE = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOT_SUSP = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, clear previous result
        logic apply;    // evaluate and commit decision (state writes, pushes, dispatch)
        logic rm_start; // begin queue removal walk
        logic rm_step;  // one walk step
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_rm;  // committed decision needs id removed from queue
        logic rm_done;  // walk finished
    } t_stat;

endpackage

/* rtl/rrts_ctrl.sv */
// ============================================================================
// rrts_ctrl: sequencing controller
// Accepts a request, steps the datapath through capture, decide-and-commit and an
// optional queue walk, then presents the result word.
// ============================================================================
module rrts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rrts_pkg::t_cmd o_cmd,
    input  rrts_pkg::t_stat i_stat
);
    import rrts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_APPLY = 5'b00010,
        S_RMGO  = 5'b00100,
        S_WALK  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_RMGO;
            end
            S_RMGO: begin
                if (i_stat.need_rm) begin
                    o_cmd.rm_start = 1'b1;
                    n_state        = S_WALK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WALK: begin
                o_cmd.rm_step = 1'b1;
                if (i_stat.rm_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

/* rtl/rrts_dp.sv */
// ============================================================================
// rrts_dp: scheduler datapath
// Thread tables, ready queue as a circular buffer, and the removal walk that
// closes the gap left by an id taken out of the middle of the queue.
// ============================================================================
module rrts_dp #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rrts_pkg::t_cmd  i_cmd,
    output rrts_pkg::t_stat o_stat,
    input  logic [2:0]      i_req_type,
    input  logic [3:0]      i_target_id,
    output logic [2:0]      o_status,
    output logic [3:0]      o_created_id,
    output logic [3:0]      o_running_now,
    output logic            o_switched
);
    import rrts_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_THREADS);
    localparam logic [IW:0]   NONE = (IW+1)'(MAX_THREADS);

    logic [2:0]  r_ts  [MAX_THREADS];
    logic [IW:0] r_wt  [MAX_THREADS];
    logic [IW-1:0] r_q [MAX_THREADS];
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_cnt, r_made;
    logic [IW-1:0] r_cur;

    // latched request
    logic [2:0]    r_req;
    logic [CW-1:0] r_tgt;

    // decision
    logic [2:0] r_status;
    logic [3:0] r_created;
    logic       r_sw;

    // removal walk
    logic          r_need_rm, r_walking, r_found;
    logic [IW-1:0] r_rm_id;
    logic [CW-1:0] r_pos;

    function automatic logic [IW-1:0] qidx(input logic [IW-1:0] h, input logic [CW-1:0] p);
        logic [IW:0] s;
        s = {1'b0, h} + (IW+1)'(p);
        if (s >= NONE) s = s - NONE;
        return s[IW-1:0];
    endfunction

    logic [IW-1:0] tix, wix;
    logic [2:0]    ts, wts;
    logic [IW:0]   w;
    logic          tgt_ok, wakes, is_cur;
    assign tgt_ok = (r_tgt < r_made);
    assign tix    = r_tgt[IW-1:0];
    assign ts     = r_ts[tix];
    assign w      = r_wt[tix];
    assign wix    = w[IW-1:0];
    assign wts    = r_ts[wix];
    assign wakes  = (w < NONE) && (wts == TS_BLOCKED);
    assign is_cur = (tix == r_cur);

    logic [IW-1:0] head_id;
    assign head_id = r_q[r_head];

    // walk access
    logic [IW-1:0] wp, wn;
    assign wp = qidx(r_head, r_pos);
    assign wn = qidx(r_head, r_pos + CW'(1));

    logic [CW-1:0] made0;
    assign made0 = (r_made == '0) ? CW'(1) : r_made;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_ts[i] <= TS_UNUSED;
                r_wt[i] <= NONE;
            end
            r_head    <= '0;
            r_cnt     <= '0;
            r_made    <= '0;
            r_cur     <= '0;
            r_need_rm <= 1'b0;
            r_walking <= 1'b0;
            r_found   <= 1'b0;
            r_pos     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_req     <= i_req_type;
                r_tgt     <= CW'(i_target_id);
                r_need_rm <= 1'b0;
                r_status  <= ST_OK;
                r_created <= '0;
                r_sw      <= 1'b0;
            end
            if (i_cmd.apply) begin
                // one event, all state rows read before this edge
                if (r_req == REQ_CREATE) begin
                    if (r_made == '0) begin
                        r_ts[0] <= TS_RUNNING;
                        r_cur   <= '0;
                    end
                    if (made0 >= MAXC) begin
                        r_status <= ST_FULL;
                        r_made   <= made0;
                    end else begin
                        r_created <= 4'(made0);
                        r_ts[made0[IW-1:0]] <= TS_READY;
                        r_wt[made0[IW-1:0]] <= NONE;
                        r_q[qidx(r_head, r_cnt)] <= made0[IW-1:0];
                        r_cnt  <= r_cnt + CW'(1);
                        r_made <= made0 + CW'(1);
                    end
                end else if (r_made == '0 || r_req > REQ_TERMINATE) begin
                    r_status <= ST_INVALID;
                end else if (r_req == REQ_YIELD) begin
                    if (r_cnt != '0) begin
                        // push current then pop head: head moves, count stays
                        r_ts[r_cur] <= TS_READY;
                        r_q[qidx(r_head, r_cnt)] <= r_cur;
                        r_head <= qidx(r_head, CW'(1));
                        r_cur  <= head_id;
                        r_ts[head_id] <= TS_RUNNING;
                        r_sw   <= 1'b1;
                    end
                end else if (!tgt_ok) begin
                    r_status <= ST_INVALID;
                end else begin
                    case (r_req)
                        REQ_JOIN: begin
                            if (is_cur) r_status <= ST_INVALID;
                            else if (ts == TS_FINISHED) r_status <= ST_OK;
                            else if (r_cnt == '0) r_status <= ST_EMPTY;
                            else begin
                                r_wt[tix]  <= {1'b0, r_cur};
                                r_ts[r_cur] <= TS_BLOCKED;
                                r_head <= qidx(r_head, CW'(1));
                                r_cnt  <= r_cnt - CW'(1);
                                r_cur  <= head_id;
                                r_ts[head_id] <= TS_RUNNING;
                                r_sw   <= 1'b1;
                            end
                        end
                        REQ_SUSPEND: begin
                            if (is_cur) begin
                                if (r_cnt == '0) r_status <= ST_EMPTY;
                                else begin
                                    r_ts[tix] <= TS_SUSPENDED;
                                    r_head <= qidx(r_head, CW'(1));
                                    r_cnt  <= r_cnt - CW'(1);
                                    r_cur  <= head_id;
                                    r_ts[head_id] <= TS_RUNNING;
                                    r_sw   <= 1'b1;
                                end
                            end else if (ts != TS_FINISHED) begin
                                if (ts == TS_READY) begin
                                    r_need_rm <= 1'b1;
                                    r_rm_id   <= tix;
                                end
                                r_ts[tix] <= TS_SUSPENDED;
                            end
                        end
                        REQ_RESUME: begin
                            if (ts != TS_SUSPENDED) r_status <= ST_NOT_SUSP;
                            else begin
                                r_ts[tix] <= TS_READY;
                                r_q[qidx(r_head, r_cnt)] <= tix;
                                r_cnt <= r_cnt + CW'(1);
                            end
                        end
                        default: begin // terminate
                            if (ts == TS_FINISHED) r_status <= ST_OK;
                            else if (is_cur && r_cnt == '0 && !wakes) r_status <= ST_EMPTY;
                            else if (is_cur) begin
                                // cur unqueued: push waiter+pop, or it runs
                                r_wt[tix] <= NONE;
                                r_ts[tix] <= TS_FINISHED;
                                r_sw <= 1'b1;
                                if (r_cnt == '0) begin
                                    r_cur <= wix;
                                    r_ts[wix] <= TS_RUNNING;
                                end else begin
                                    if (wakes) begin
                                        r_ts[wix] <= TS_READY;
                                        r_q[qidx(r_head, r_cnt)] <= wix;
                                    end else begin
                                        r_cnt <= r_cnt - CW'(1);
                                    end
                                    r_head <= qidx(r_head, CW'(1));
                                    r_cur  <= head_id;
                                    r_ts[head_id] <= TS_RUNNING;
                                end
                            end else begin
                                if (wakes) begin
                                    r_ts[wix] <= TS_READY;
                                    r_q[qidx(r_head, r_cnt)] <= wix;
                                    r_cnt <= r_cnt + CW'(1);
                                end
                                r_wt[tix] <= NONE;
                                r_ts[tix] <= TS_FINISHED;
                                if (ts == TS_READY) begin
                                    r_need_rm <= 1'b1;
                                    r_rm_id   <= tix;
                                end
                            end
                        end
                    endcase
                end
            end
            if (i_cmd.rm_start) begin
                r_walking <= 1'b1;
                r_found   <= 1'b0;
                r_pos     <= '0;
            end
            if (i_cmd.rm_step) begin
                // find the id, then shift later entries down one per cycle
                if (r_pos + CW'(1) >= r_cnt) begin
                    r_walking <= 1'b0;
                    r_need_rm <= 1'b0;
                    if (r_found || r_q[wp] == r_rm_id) r_cnt <= r_cnt - CW'(1);
                end else begin
                    if (r_found || r_q[wp] == r_rm_id) begin
                        r_found <= 1'b1;
                        r_q[wp] <= r_q[wn];
                    end
                    r_pos <= r_pos + CW'(1);
                end
            end
        end
    end

    assign o_stat.need_rm = r_need_rm;
    assign o_stat.rm_done = r_walking && (r_pos + CW'(1) >= r_cnt);

    assign o_status      = r_status;
    assign o_created_id  = r_created;
    assign o_running_now = 4'(r_cur);
    assign o_switched    = r_sw;

endmodule

/* rtl/round_robin_thread_scheduler.sv */
// ============================================================================
// round_robin_thread_scheduler: top level
// Hardware round-robin scheduler: thread table, waiter table, FIFO ready queue.
// ============================================================================
// Sequence: after accept the controller runs APPLY and RMGO, then shows the
//   result word in OUT; a suspend or terminate of a queued thread adds the
//   WALK state, one step per queued entry (at most MAX_THREADS - 1 entries).
// Throughput: one word in flight; next word accepted the cycle after the
//   result word is taken.
// Reset: synchronous active low; all threads unused, queue empty, no waiters.
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [2:0] req_type, [6:3] target_id, [7] zero
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata   // [2:0] status, [6:3] created_id,
                                       // [10:7] running_now, [11] switched
);
    import rrts_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [2:0] status;
    logic [3:0] created_id, running_now;
    logic       switched;

    // sequencing
    rrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // tables and queue
    rrts_dp #(.MAX_THREADS(MAX_THREADS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (s_axis_tdata[2:0]),
        .i_target_id   (s_axis_tdata[6:3]),
        .o_status      (status),
        .o_created_id  (created_id),
        .o_running_now (running_now),
        .o_switched    (switched)
    );

    assign m_axis_tdata = {4'b0, switched, running_now, created_id, status};

    // a word is captured only when the port is ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> s_axis_tready && s_axis_tvalid)
        else $error("load without accept");

    // result never shown while the removal walk runs
    a_no_out_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rm_step |-> !m_axis_tvalid)
        else $error("result during walk");

    // status field stays in its code range
    a_status_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> status <= ST_FULL)
        else $error("bad status");

endmodule
